>>> rtl/pkcs_pkg.sv
// Package: constants, status codes and DigestInfo table for the PKCS#1 v1.5 padding checker.
`timescale 1ns / 1ps
`default_nettype none

package pkcs_pkg;

    // Layout sizes
    localparam int HASH_BYTES      = 32;
    localparam int PREFIX_BYTES    = 19;
    localparam int MAX_BLOCK_BYTES = 512;
    localparam int MIN_BLOCK_BYTES = 3 + PREFIX_BYTES + HASH_BYTES;

    // Field widths
    localparam int LEN_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int PREFIX_W = $clog2(PREFIX_BYTES);

    localparam logic [LEN_W-1:0] BLOCK_LENGTH_RESET = LEN_W'(128);

    // Fixed byte values of the layout
    localparam logic [BYTE_W-1:0] BYTE_HEADER0   = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_HEADER1   = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_PAD       = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_SEPARATOR = 8'h00;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK              = 3'd0,
        ST_INVALID_LENGTH  = 3'd1,
        ST_BAD_HEADER      = 3'd2,
        ST_BAD_SEPARATOR   = 3'd3,
        ST_BAD_PADDING     = 3'd4,
        ST_PREFIX_MISMATCH = 3'd5
    } t_status;

    // SHA-256 DigestInfo prefix, one byte per index
    function automatic logic [BYTE_W-1:0] digest_info_byte(input logic [PREFIX_W-1:0] k);
        logic [BYTE_W-1:0] b;
        case (k)
            5'd0:    b = 8'h30;
            5'd1:    b = 8'h31;
            5'd2:    b = 8'h30;
            5'd3:    b = 8'h0d;
            5'd4:    b = 8'h06;
            5'd5:    b = 8'h09;
            5'd6:    b = 8'h60;
            5'd7:    b = 8'h86;
            5'd8:    b = 8'h48;
            5'd9:    b = 8'h01;
            5'd10:   b = 8'h65;
            5'd11:   b = 8'h03;
            5'd12:   b = 8'h04;
            5'd13:   b = 8'h02;
            5'd14:   b = 8'h01;
            5'd15:   b = 8'h05;
            5'd16:   b = 8'h00;
            5'd17:   b = 8'h04;
            5'd18:   b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pkcs_ifs.sv
// Interfaces: byte input channel and check result channel.
`timescale 1ns / 1ps
`default_nettype none

interface pkcs_byte_if
    import pkcs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] block_byte;

    modport source (output valid, output block_byte, input ready);
    modport sink   (input valid, input block_byte, output ready);
endinterface

interface pkcs_result_if
    import pkcs_pkg::*;
;
    logic             valid;
    logic             ready;
    t_status          check_status;
    logic [LEN_W-1:0] hash_offset;

    modport source (output valid, output check_status, output hash_offset, input ready);
    modport sink   (input valid, input check_status, input hash_offset, output ready);
endinterface

`default_nettype wire

>>> rtl/pkcs1_v15_padding_checker.sv
// Top level: streaming EMSA-PKCS1-v1_5 (SHA-256) padding checker.
//
//  Channel    Dir  Beat contents                        Notes
//  i_block    in   block_byte[7:0]                      one block byte, index 0 first
//  o_result   out  check_status[2:0], hash_offset[9:0]  one beat at the last byte of a block
//  i_cfg_*    in   block length[9:0]                    write while idle, reset 128
//
// Each byte is checked against position and length in the cycle after its beat,
// while it sits in the input register; a block-ending byte's result is loaded into
// the output register when that byte advances, so o_result.valid follows the last
// byte's beat via both registers. One byte per cycle is sustained outside a stall.
// The input register only stalls when a block-ending byte meets a result still
// waiting on o_result. Reset clears position, error flags and both valid bits.
`timescale 1ns / 1ps
`default_nettype none

module pkcs1_v15_padding_checker
    import pkcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LEN_W-1:0]  i_cfg_data,
    pkcs_byte_if.sink              i_block,
    pkcs_result_if.source          o_result
);

    // Registers
    logic [LEN_W-1:0]  r_block_length;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [LEN_W-1:0]  r_byte_pos;
    logic              r_header_err;
    logic              r_separator_err;
    logic              r_padding_err;
    logic              r_prefix_err;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [LEN_W-1:0]  r_out_offset;

    // Check logic
    logic                len_ok;
    logic [LEN_W-1:0]    prefix_start;
    logic [LEN_W-1:0]    sep_pos;
    logic [LEN_W-1:0]    prefix_rel;
    logic                in_prefix;
    logic                header_hit;
    logic                separator_hit;
    logic                padding_hit;
    logic                prefix_hit;
    logic                is_last;
    logic                advance;
    logic                n_header_err;
    logic                n_separator_err;
    logic                n_padding_err;
    logic                n_prefix_err;
    t_status             n_status;
    logic [LEN_W-1:0]    n_offset;

    // Position of each layout field for the current length
    always_comb begin
        len_ok       = (r_block_length >= LEN_W'(MIN_BLOCK_BYTES))
                    && (r_block_length <= LEN_W'(MAX_BLOCK_BYTES));
        prefix_start = r_block_length - LEN_W'(PREFIX_BYTES + HASH_BYTES);
        sep_pos      = prefix_start - LEN_W'(1);
        prefix_rel   = r_byte_pos - prefix_start;
        in_prefix    = (r_byte_pos >= prefix_start)
                    && (r_byte_pos < prefix_start + LEN_W'(PREFIX_BYTES));
    end

    // Per-byte checks, only when the length frames a valid layout
    always_comb begin
        header_hit    = len_ok
                     && (((r_byte_pos == LEN_W'(0)) && (r_in_byte != BYTE_HEADER0))
                      || ((r_byte_pos == LEN_W'(1)) && (r_in_byte != BYTE_HEADER1)));
        separator_hit = len_ok && (r_byte_pos == sep_pos) && (r_in_byte != BYTE_SEPARATOR);
        padding_hit   = len_ok && (r_byte_pos >= LEN_W'(2)) && (r_byte_pos < sep_pos)
                     && (r_in_byte != BYTE_PAD);
        prefix_hit    = len_ok && in_prefix
                     && (r_in_byte != digest_info_byte(prefix_rel[PREFIX_W-1:0]));
    end

    // Fold this byte into the sticky flags and pick the first failing check
    always_comb begin
        n_header_err    = r_header_err    | header_hit;
        n_separator_err = r_separator_err | separator_hit;
        n_padding_err   = r_padding_err   | padding_hit;
        n_prefix_err    = r_prefix_err    | prefix_hit;
        n_offset        = '0;
        if (!len_ok) begin
            n_status = ST_INVALID_LENGTH;
        end else if (n_header_err) begin
            n_status = ST_BAD_HEADER;
        end else if (n_separator_err) begin
            n_status = ST_BAD_SEPARATOR;
        end else if (n_padding_err) begin
            n_status = ST_BAD_PADDING;
        end else if (n_prefix_err) begin
            n_status = ST_PREFIX_MISMATCH;
        end else begin
            n_status = ST_OK;
            n_offset = r_block_length - LEN_W'(HASH_BYTES);
        end
    end

    // Hold a block-ending byte while the previous result is still waiting
    assign is_last = ({1'b0, r_byte_pos} + (LEN_W+1)'(1)) >= {1'b0, r_block_length};
    assign advance = r_in_valid && (!is_last || !r_out_valid || o_result.ready);

    assign i_block.ready         = !r_in_valid || advance;
    assign o_result.valid        = r_out_valid;
    assign o_result.check_status = r_out_status;
    assign o_result.hash_offset  = r_out_offset;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length  <= BLOCK_LENGTH_RESET;
            r_in_valid      <= 1'b0;
            r_byte_pos      <= '0;
            r_header_err    <= 1'b0;
            r_separator_err <= 1'b0;
            r_padding_err   <= 1'b0;
            r_prefix_err    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_length <= i_cfg_data;
            end
            if (i_block.ready) begin
                r_in_valid <= i_block.valid;
            end
            if (advance && is_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (is_last) begin
                    r_byte_pos      <= '0;
                    r_header_err    <= 1'b0;
                    r_separator_err <= 1'b0;
                    r_padding_err   <= 1'b0;
                    r_prefix_err    <= 1'b0;
                end else begin
                    r_byte_pos      <= r_byte_pos + LEN_W'(1);
                    r_header_err    <= n_header_err;
                    r_separator_err <= n_separator_err;
                    r_padding_err   <= n_padding_err;
                    r_prefix_err    <= n_prefix_err;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_block.ready && i_block.valid) begin
            r_in_byte <= i_block.block_byte;
        end
        if (advance && is_last) begin
            r_out_status <= n_status;
            r_out_offset <= n_offset;
        end
    end

    // Assertions
    a_offset_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_offset == '0))
        else $error("hash offset nonzero on failed check");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status <= ST_PREFIX_MISMATCH))
        else $error("status code out of range");

    a_block_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_last) |=> ((r_byte_pos == '0) && !r_header_err && !r_separator_err
                                  && !r_padding_err && !r_prefix_err && r_out_valid))
        else $error("block end did not clear position and flags");

    a_stalled_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte lost");

endmodule

`default_nettype wire

>>> verif/tb_pkcs1_v15_padding_checker.sv
// Testbench for the PKCS#1 v1.5 padding checker: byte streams in, predicted verdicts checked.
`timescale 1ns / 1ps

module tb_pkcs1_v15_padding_checker;
    import pkcs_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [LEN_W-1:0] offset;
    } t_verdict;

    // Kinds of damage applied to an otherwise well-formed block
    typedef enum int {
        FLT_NONE,
        FLT_HEADER0,
        FLT_HEADER1,
        FLT_SEPARATOR,
        FLT_PADDING,
        FLT_PREFIX,
        FLT_MULTI,
        FLT_NOISE
    } t_fault;

    localparam int RX_HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ITEMS    = 110;
    localparam int RANDOM_VERDICTS = 6;
    localparam int HOLD_ITEMS      = 16;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_data;

    pkcs_byte_if   blk_if ();
    pkcs_result_if res_if ();

    pkcs1_v15_padding_checker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_block    (blk_if),
        .o_result   (res_if)
    );

    logic [BYTE_W-1:0] digest_prefix [PREFIX_BYTES] = '{
        8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86,
        8'h48, 8'h01, 8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05,
        8'h00, 8'h04, 8'h20
    };

    // Bytes waiting to be sent and verdicts waiting to arrive
    logic [BYTE_W-1:0] pending_bytes [$];
    t_verdict          expected_verdicts [$];

    // Shadow of the checker state and of the length register
    int model_len;
    int chk_pos;
    bit hdr_err;
    bit sep_err;
    bit pad_err;
    bit pfx_err;

    int mismatches;
    int verdicts_predicted;
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_seq;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("ERROR at %0t: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Advance the shadow checker by one accepted byte; queue a verdict at block end
    task automatic predict_block_byte(input logic [BYTE_W-1:0] b);
        int       len;
        int       pos;
        int       t_off;
        int       sep;
        bit       len_ok;
        t_verdict v;
        len    = model_len;
        pos    = chk_pos;
        len_ok = (len >= MIN_BLOCK_BYTES) && (len <= MAX_BLOCK_BYTES);
        t_off  = len - (PREFIX_BYTES + HASH_BYTES);
        sep    = t_off - 1;
        if (len_ok) begin
            if (pos == 0 && b != BYTE_HEADER0) hdr_err = 1'b1;
            if (pos == 1 && b != BYTE_HEADER1) hdr_err = 1'b1;
            if (pos == sep && b != BYTE_SEPARATOR) sep_err = 1'b1;
            if (pos >= 2 && pos < sep && b != BYTE_PAD) pad_err = 1'b1;
            if (pos >= t_off && pos < t_off + PREFIX_BYTES
                && b != digest_prefix[pos - t_off]) pfx_err = 1'b1;
        end
        if (pos + 1 < len) begin
            chk_pos = pos + 1;
        end else begin
            v.offset = '0;
            if (!len_ok) v.status = ST_INVALID_LENGTH;
            else if (hdr_err) v.status = ST_BAD_HEADER;
            else if (sep_err) v.status = ST_BAD_SEPARATOR;
            else if (pad_err) v.status = ST_BAD_PADDING;
            else if (pfx_err) v.status = ST_PREFIX_MISMATCH;
            else begin
                v.status = ST_OK;
                v.offset = LEN_W'(len - HASH_BYTES);
            end
            expected_verdicts.push_back(v);
            verdicts_predicted++;
            chk_pos = 0;
            hdr_err = 1'b0;
            sep_err = 1'b0;
            pad_err = 1'b0;
            pfx_err = 1'b0;
        end
    endtask

    // Byte driver: one beat per item, random gap after each item when idling is on
    always @(posedge i_clk) begin : drive_bytes
        int                tx_gap;
        bit                next_valid;
        logic [BYTE_W-1:0] next_byte;
        if (!i_rst_n) begin
            tx_gap = 0;
            blk_if.valid <= 1'b0;
        end else begin
            if (blk_if.valid && blk_if.ready) begin
                predict_block_byte(blk_if.block_byte);
            end
            if (!blk_if.valid || blk_if.ready) begin
                next_valid = 1'b0;
                next_byte  = blk_if.block_byte;
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_bytes.size() != 0) begin
                    next_byte  = pending_bytes.pop_front();
                    next_valid = 1'b1;
                    tx_gap     = tx_idle_on ? $urandom_range(0, 9) : 0;
                end
                blk_if.valid      <= next_valid;
                blk_if.block_byte <= next_byte;
            end
        end
    end

    // Verdict monitor: compare each beat, stall ready at random and on request
    always @(posedge i_clk) begin : watch_verdicts
        int       rx_gap;
        int       rx_hold_cnt;
        int       rx_hold_seen;
        bit       next_ready;
        t_verdict want;
        if (!i_rst_n) begin
            rx_gap       = 0;
            rx_hold_cnt  = 0;
            rx_hold_seen = rx_hold_seq;
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("verdict with none expected", res_if.check_status, -1);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (res_if.check_status !== want.status)
                        report_mismatch("check_status", res_if.check_status, want.status);
                    if (res_if.hash_offset !== want.offset)
                        report_mismatch("hash_offset", res_if.hash_offset, want.offset);
                end
                rx_gap = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (rx_hold_seq != rx_hold_seen) begin
                rx_hold_seen = rx_hold_seq;
                rx_hold_cnt  = RX_HOLD_CYCLES;
            end
            next_ready = 1'b0;
            if (rx_hold_cnt > 0) begin
                rx_hold_cnt--;
            end else if (rx_gap > 0) begin
                rx_gap--;
            end else begin
                next_ready = 1'b1;
            end
            res_if.ready <= next_ready;
        end
    end

    // Damage one well-formed block image in the given way
    task automatic apply_fault(ref logic [BYTE_W-1:0] img [$], input int len,
                               input t_fault flt);
        int t_off;
        int sep;
        int idx;
        t_off = len - (PREFIX_BYTES + HASH_BYTES);
        sep   = t_off - 1;
        case (flt)
            FLT_HEADER0: begin
                img[0] = BYTE_W'($urandom_range(1, 255));
            end
            FLT_HEADER1: begin
                img[1] = BYTE_HEADER1 ^ BYTE_W'($urandom_range(1, 255));
            end
            FLT_SEPARATOR: begin
                img[sep] = BYTE_W'($urandom_range(1, 255));
            end
            FLT_PADDING: begin
                if (sep > 2) begin
                    idx = $urandom_range(2, sep - 1);
                    img[idx] = BYTE_W'($urandom_range(0, 254));
                end
            end
            FLT_PREFIX: begin
                idx = t_off + $urandom_range(0, PREFIX_BYTES - 1);
                img[idx] = img[idx] ^ BYTE_W'($urandom_range(1, 255));
            end
            FLT_MULTI: begin
                repeat ($urandom_range(2, 3))
                    apply_fault(img, len, t_fault'($urandom_range(FLT_HEADER0, FLT_PREFIX)));
            end
            FLT_NOISE: begin
                foreach (img[i]) img[i] = BYTE_W'($urandom_range(0, 255));
            end
            default: ;
        endcase
    endtask

    // Build one block image; lengths out of range get random bytes
    task automatic make_block(ref logic [BYTE_W-1:0] img [$], input int len,
                              input t_fault flt);
        int t_off;
        int n;
        img.delete();
        n = (len < 1) ? 1 : len;
        for (int i = 0; i < n; i++) img.push_back(BYTE_W'($urandom_range(0, 255)));
        if (len >= MIN_BLOCK_BYTES && len <= MAX_BLOCK_BYTES) begin
            t_off = len - (PREFIX_BYTES + HASH_BYTES);
            img[0] = BYTE_HEADER0;
            img[1] = BYTE_HEADER1;
            for (int i = 2; i < t_off - 1; i++) img[i] = BYTE_PAD;
            img[t_off - 1] = BYTE_SEPARATOR;
            for (int k = 0; k < PREFIX_BYTES; k++) img[t_off + k] = digest_prefix[k];
            apply_fault(img, len, flt);
        end
    endtask

    task automatic push_bytes(ref logic [BYTE_W-1:0] img [$], input int first,
                              input int count);
        for (int i = first; i < first + count; i++) pending_bytes.push_back(img[i]);
    endtask

    // Wait until every byte is sent and every verdict is in, then let the pipe settle
    task automatic drain_all();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || blk_if.valid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_block_length(input int len);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= LEN_W'(len);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        model_len = len;
        @(negedge i_clk);
    endtask

    // Stimulus: directed cases, then random blocks
    initial begin : run_stimulus
        logic [BYTE_W-1:0] img [$];
        int                random_items;
        int                verdict_base;
        int                len;
        int                nblk;
        int                sweep;
        int                pick;
        t_fault            flt;

        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        blk_if.valid      = 1'b0;
        blk_if.block_byte = '0;
        res_if.ready      = 1'b0;
        model_len         = BLOCK_LENGTH_RESET;
        chk_pos           = 0;
        hdr_err           = 1'b0;
        sep_err           = 1'b0;
        pad_err           = 1'b0;
        pfx_err           = 1'b0;
        mismatches        = 0;
        verdicts_predicted = 0;
        tx_idle_on        = 1'b0;
        rx_idle_on        = 1'b0;
        rx_hold_seq       = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset length: one clean block
        make_block(img, BLOCK_LENGTH_RESET, FLT_NONE);
        push_bytes(img, 0, img.size());
        drain_all();

        // Shrink the length mid-block: start a 60-byte block under the reset length
        make_block(img, 60, FLT_NONE);
        push_bytes(img, 0, 10);
        drain_all();
        set_block_length(60);
        push_bytes(img, 10, 50);
        drain_all();

        // Shrink the length below the current position: the next byte ends the block
        set_block_length(20);
        push_bytes(img, 0, 12);
        drain_all();
        set_block_length(4);
        push_bytes(img, 12, 1);
        drain_all();

        // Zero length: every byte is its own block
        set_block_length(0);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hA5);
        drain_all();

        // Hold off the verdict side while bytes keep coming, so the input backs up
        rx_hold_seq = rx_hold_seq + 1;
        for (int i = 0; i < HOLD_ITEMS; i++)
            pending_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        drain_all();

        // Tiny lengths
        set_block_length(1);
        push_bytes(img, 0, 3);
        drain_all();
        set_block_length(2);
        push_bytes(img, 0, 4);
        drain_all();

        // All-ones length: a bad header goes unchecked, then finish at the minimum length
        set_block_length((1 << LEN_W) - 1);
        make_block(img, MIN_BLOCK_BYTES, FLT_NONE);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hFF);
        drain_all();
        set_block_length(MIN_BLOCK_BYTES);
        push_bytes(img, 2, MIN_BLOCK_BYTES - 2);
        drain_all();

        // Maximum length: the header is checked, then finish at the minimum length
        set_block_length(MAX_BLOCK_BYTES);
        make_block(img, MIN_BLOCK_BYTES, FLT_NONE);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h02);
        drain_all();
        set_block_length(MIN_BLOCK_BYTES);
        push_bytes(img, 2, MIN_BLOCK_BYTES - 2);
        drain_all();

        // Random part: mostly short well-formed blocks, some damaged, some bad lengths
        random_items = 0;
        verdict_base = verdicts_predicted;
        sweep        = FLT_NONE;
        while (random_items < RANDOM_ITEMS
               || verdicts_predicted - verdict_base < RANDOM_VERDICTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) len = $urandom_range(MIN_BLOCK_BYTES, MIN_BLOCK_BYTES + 12);
            else len = $urandom_range(0, MIN_BLOCK_BYTES - 1);
            set_block_length(len);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (len < 8) nblk = $urandom_range(2, 8);
            else nblk = 1;
            for (int b = 0; b < nblk; b++) begin
                if (sweep <= FLT_NOISE) begin
                    flt = t_fault'(sweep);
                    if (len >= MIN_BLOCK_BYTES) sweep++;
                end else if ($urandom_range(0, 1) == 0) begin
                    flt = FLT_NONE;
                end else begin
                    flt = t_fault'($urandom_range(FLT_HEADER0, FLT_NOISE));
                end
                make_block(img, len, flt);
                push_bytes(img, 0, img.size());
                random_items += img.size();
            end
            drain_all();
        end

        drain_all();
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
